// ===== rtl/core/txfmt_pkg.sv =====
package txfmt_pkg;

    localparam int TEXEL_W     = 32;
    localparam int RGBA_W      = 32;
    localparam int NBYTES_W    = 3;
    localparam int FMT_W       = 4;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - RGBA_W - NBYTES_W - 1;

    typedef enum logic [FMT_W-1:0] {
        FMT_A8       = 4'd0,
        FMT_I8       = 4'd1,
        FMT_AI44     = 4'd2,
        FMT_RGB565   = 4'd3,
        FMT_ARGB1555 = 4'd4,
        FMT_AI88     = 4'd5,
        FMT_ARGB4444 = 4'd6,
        FMT_ARGB8888 = 4'd7
    } t_texel_format;

    localparam logic [NBYTES_W-1:0] NBYTES_NONE = 3'd0;
    localparam logic [NBYTES_W-1:0] NBYTES_1    = 3'd1;
    localparam logic [NBYTES_W-1:0] NBYTES_2    = 3'd2;
    localparam logic [NBYTES_W-1:0] NBYTES_4    = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic                format_error;
        logic [NBYTES_W-1:0] source_bytes;
        logic [RGBA_W-1:0]   rgba_word;
    } t_result;

endpackage

// ===== rtl/core/txfmt_expand.sv =====
module txfmt_expand (
    input  logic [txfmt_pkg::TEXEL_W-1:0] i_texel,
    input  logic [txfmt_pkg::FMT_W-1:0]   i_format,
    output txfmt_pkg::t_result            o_result
);
    import txfmt_pkg::*;

    logic [7:0] b8;
    logic [7:0] hi8;
    logic [7:0] ai_a;
    logic [7:0] ai_i;

    assign b8   = i_texel[7:0];
    assign hi8  = i_texel[15:8];
    assign ai_a = {i_texel[7:4], i_texel[7:4]};
    assign ai_i = {i_texel[3:0], i_texel[3:0]};

    always_comb begin
        o_result = '0;
        unique case (i_format)
            FMT_A8: begin
                o_result.rgba_word    = {b8, b8, b8, b8};
                o_result.source_bytes = NBYTES_1;
            end
            FMT_I8: begin
                o_result.rgba_word    = {ALPHA_OPAQUE, b8, b8, b8};
                o_result.source_bytes = NBYTES_1;
            end
            FMT_AI44: begin
                o_result.rgba_word    = {ai_a, ai_i, ai_i, ai_i};
                o_result.source_bytes = NBYTES_1;
            end
            FMT_RGB565: begin
                o_result.rgba_word    = {ALPHA_OPAQUE, i_texel[4:0], 3'b000,
                                         i_texel[10:5], 2'b00, i_texel[15:11], 3'b000};
                o_result.source_bytes = NBYTES_2;
            end
            FMT_ARGB1555: begin
                o_result.rgba_word    = {{8{i_texel[15]}}, i_texel[4:0], 3'b000,
                                         i_texel[9:5], 3'b000, i_texel[14:10], 3'b000};
                o_result.source_bytes = NBYTES_2;
            end
            FMT_AI88: begin
                o_result.rgba_word    = {hi8, b8, b8, b8};
                o_result.source_bytes = NBYTES_2;
            end
            FMT_ARGB4444: begin
                o_result.rgba_word    = {i_texel[15:12], 4'h0, i_texel[3:0], 4'h0,
                                         i_texel[7:4], 4'h0, i_texel[11:8], 4'h0};
                o_result.source_bytes = NBYTES_2;
            end
            FMT_ARGB8888: begin
                // red and blue bytes trade places
                o_result.rgba_word    = {i_texel[31:24], i_texel[7:0],
                                         i_texel[15:8], i_texel[23:16]};
                o_result.source_bytes = NBYTES_4;
            end
            default: begin
                o_result.rgba_word    = '0;
                o_result.source_bytes = NBYTES_NONE;
                o_result.format_error = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/txfmt_out_stage.sv =====
module txfmt_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  txfmt_pkg::t_result              i_result,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [txfmt_pkg::M_TDATA_W-1:0] o_data
);
    import txfmt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // a held result only blocks the stage when the sink is stalled
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{M_PAD_W{1'b0}}, r_result};

endmodule

// ===== rtl/core/texel_format_to_rgba8888_unit.sv =====
// Texel format expander: each source texel taken on the slave stream comes out on the
// master stream as one A,B,G,R word (A in bits 31:24, R in 7:0) along with the source
// byte count and an unknown-format flag. The unit takes a texel every clock unless the
// master side stalls it; each result passes the input register, then the conversion
// logic into the output register, and backpressure on the master side stalls both
// stages through a combinational ready path. The format register takes effect for
// texels still held inside, so change it only with the unit empty.
module texel_format_to_rgba8888_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [txfmt_pkg::FMT_W-1:0]     i_cfg_wr_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] source_texel
    input  logic [txfmt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] rgba_word, [34:32] source_bytes, [35] format_error, [39:36] zero
    output logic [txfmt_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import txfmt_pkg::*;

    logic [FMT_W-1:0]   r_format;
    logic               r_in_valid;
    logic [TEXEL_W-1:0] r_in_texel;
    logic               out_ready;
    logic               in_xfer;
    t_result            conv_result;

    assign o_s_axis_tready = !r_in_valid || out_ready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_A8;
        end else if (i_cfg_wr_en) begin
            r_format <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_texel <= i_s_axis_tdata[TEXEL_W-1:0];
        end
    end

    txfmt_expand u_expand (
        .i_texel  (r_in_texel),
        .i_format (r_format),
        .o_result (conv_result)
    );

    txfmt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (out_ready),
        .i_result (conv_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_xfer_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_in_valid)
        else $error("accepted texel did not reach the input register");

    a_stalled_texel_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> (r_in_valid && $stable(r_in_texel)))
        else $error("stalled texel lost or changed");

    a_error_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[35]) |->
            (o_m_axis_tdata[34:0] == '0))
        else $error("unknown format result carries data");

    a_byte_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[34:32] == NBYTES_NONE || o_m_axis_tdata[34:32] == NBYTES_1 ||
             o_m_axis_tdata[34:32] == NBYTES_2 || o_m_axis_tdata[34:32] == NBYTES_4))
        else $error("illegal source byte count");
`endif

endmodule
